// ===== rtl/mcvl_pkg.sv =====
// Shared types, codes and constants of the first-visit Monte Carlo value learner.
package mcvl_pkg;

    localparam int STATE_COUNT_DEF  = 1024;
    localparam int ACTION_COUNT_DEF = 7;
    localparam int STEP_DEPTH_DEF   = 4096;

    localparam int STATE_W    = 10;
    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 48;
    localparam int COUNT_W    = 32;
    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0]         DISCOUNT_RST = 16'd65535;
    localparam logic [RATE_W-1:0]         START_RST    = 16'd6554;
    localparam logic [RATE_W-1:0]         FLOOR_RST    = 16'd655;
    localparam logic [RATE_W-1:0]         DECAY_RST    = 16'd65470;
    localparam logic signed [VALUE_W-1:0] BONUS_RST    = 32'sd3276800;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_RECORD = 2'd1,
        OP_END    = 2'd2,
        OP_START  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISCOUNT    = 3'd0,
        CFG_EXPL_START  = 3'd1,
        CFG_EXPL_FLOOR  = 3'd2,
        CFG_EXPL_DECAY  = 3'd3,
        CFG_WIN_BONUS   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEL,
        ST_WALK_RD,
        ST_WALK_MUL,
        ST_WALK_G,
        ST_WALK_SUM,
        ST_WALK_DIV,
        ST_MARK_CLR,
        ST_DECAY,
        ST_RESP
    } fsm_state_t;

    typedef struct packed {
        op_t                        operation;
        logic [STATE_W-1:0]         state_index;
        logic [ACTION_W-1:0]        action_index;
        logic signed [VALUE_W-1:0]  reward_value;
        logic                       episode_won;
        logic [RATE_W-1:0]          random_fraction;
        logic [ACTION_W-1:0]        random_action;
    } in_item_t;

    typedef struct packed {
        logic [ACTION_W-1:0]        chosen_action;
        logic                       explored;
        logic signed [VALUE_W-1:0]  episode_return;
        logic [COUNT_W-1:0]         episodes_done;
        logic                       buffer_full;
    } out_item_t;

    typedef struct packed {
        logic [STATE_W-1:0]         st;
        logic [ACTION_W-1:0]        act;
        logic signed [VALUE_W-1:0]  rew;
    } step_rec_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic signed [SUM_W-1:0]    sum;
        logic [COUNT_W-1:0]         count;
    } pair_word_t;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_W-1:0]    dividend;
        logic [COUNT_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic signed [VALUE_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== rtl/mcvl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mcvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcvl_div.sv =====
// Radix-2 restoring divider: signed sum over unsigned count, truncated, saturated to 32 bits.
module mcvl_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  mcvl_pkg::div_req_t req,
    output mcvl_pkg::div_rsp_t rsp
);

    localparam int SW = mcvl_pkg::SUM_W;
    localparam int CW = mcvl_pkg::COUNT_W;
    localparam int VW = mcvl_pkg::VALUE_W;
    localparam int NW = $clog2(SW);

    logic                 load_reg, run_reg, fin_reg, done_reg, busy_reg;
    logic [NW-1:0]        cnt_reg;
    logic signed [SW-1:0] raw_reg;
    logic                 neg_reg;
    logic [CW-1:0]        dvs_reg;
    logic [CW-1:0]        rem_reg;
    logic [SW-1:0]        quo_reg;
    logic signed [VW-1:0] q_reg;

    logic [CW:0]   rem_shift;
    logic          ge;
    logic [CW:0]   rem_sub;
    logic          pos_ovf, neg_ovf;
    logic [VW-1:0] q_sat;

    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    // The magnitude of a negative quotient may reach 2^31 exactly.
    assign pos_ovf = |quo_reg[SW-1:VW-1];
    assign neg_ovf = (|quo_reg[SW-1:VW]) || (quo_reg[VW-1] && (|quo_reg[VW-2:0]));

    always_comb begin
        if (neg_reg) begin
            q_sat = neg_ovf ? {1'b1, {(VW-1){1'b0}}} : (~quo_reg[VW-1:0] + 1'b1);
        end else begin
            q_sat = pos_ovf ? {1'b0, {(VW-1){1'b1}}} : quo_reg[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                load_reg <= 1'b1;
                busy_reg <= 1'b1;
            end
            if (load_reg) begin
                load_reg <= 1'b0;
                run_reg  <= 1'b1;
                cnt_reg  <= NW'(SW - 1);
            end
            if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            raw_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        if (load_reg) begin
            neg_reg <= raw_reg[SW-1];
            quo_reg <= raw_reg[SW-1] ? (~raw_reg + 1'b1) : raw_reg;
            rem_reg <= '0;
        end
        if (run_reg) begin
            rem_reg <= ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
            quo_reg <= {quo_reg[SW-2:0], ge};
        end
        if (fin_reg) begin
            q_reg <= q_sat;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== rtl/first_visit_mc_value_learner_core.sv =====
// Top level of the first-visit Monte Carlo value learner with epsilon-greedy action selection.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_item  (mcvl_pkg::in_item_t)
//   m_        out        m_valid / m_ready    m_item  (mcvl_pkg::out_item_t)
//   cfg_      in         cfg_wr_en only       cfg_index, cfg_wdata
//
// One item is in work at a time. A greedy select reads the row one entry per cycle through the
// single read port of the pair memory; an exploring or out-of-range select does not read it.
// End episode walks the buffered steps backwards; a step whose pair was not yet seen this
// episode waits for the one-bit-per-cycle 48-bit divider, and the walk is followed by a sweep
// that clears the first-visit marks.
// After reset the pair memory and the mark memory are swept to zero, one entry per cycle,
// before the first item is taken.
// A finished result sits in the output register; the next item is accepted while it waits.
module first_visit_mc_value_learner_core #(
    parameter int STATE_COUNT  = mcvl_pkg::STATE_COUNT_DEF,
    parameter int ACTION_COUNT = mcvl_pkg::ACTION_COUNT_DEF,
    parameter int STEP_DEPTH   = mcvl_pkg::STEP_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mcvl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcvl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mcvl_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mcvl_pkg::out_item_t               m_item
);

    localparam int PAIRS = STATE_COUNT * ACTION_COUNT;
    localparam int PW    = $clog2(PAIRS);
    localparam int SW    = $clog2(STEP_DEPTH);
    localparam int SCW   = SW + 1;
    localparam int ACW   = $clog2(ACTION_COUNT + 1);
    localparam int VW    = mcvl_pkg::VALUE_W;
    localparam int SUMW  = mcvl_pkg::SUM_W;
    localparam int CW    = mcvl_pkg::COUNT_W;
    localparam int RW    = mcvl_pkg::RATE_W;
    localparam int AW    = mcvl_pkg::ACTION_W;
    localparam int PWW   = $bits(mcvl_pkg::pair_word_t);
    localparam int STW   = $bits(mcvl_pkg::step_rec_t);

    // Controller state.
    mcvl_pkg::fsm_state_t state_reg, state_next;

    // Configuration and scalar learner state.
    logic [RW-1:0]        gamma_reg, floor_reg, decay_reg, rate_reg;
    logic signed [VW-1:0] bonus_reg;
    logic [CW-1:0]        episodes_reg;
    logic [SCW-1:0]       step_cnt_reg;
    logic [PW-1:0]        clr_cnt_reg;

    // Select scan.
    logic [PW-1:0]        base_reg;
    logic [ACW-1:0]       sel_cnt_reg;
    logic signed [VW-1:0] best_val_reg;
    logic [ACW-1:0]       best_act_reg;

    // Backward walk over the step buffer.
    logic [SW-1:0]          t_reg;
    logic signed [VW-1:0]   g_reg;
    logic signed [VW+16:0]  prod_reg;
    logic signed [VW-1:0]   rew_reg;
    logic [PW-1:0]          k_reg;
    mcvl_pkg::pair_word_t   pword_reg;
    logic                   mark_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [CW-1:0]          cnt_reg;

    // Result staging and output register.
    mcvl_pkg::out_item_t res_reg;
    mcvl_pkg::out_item_t res_init;
    logic                m_valid_reg;
    mcvl_pkg::out_item_t m_item_reg;

    // Memory ports.
    logic              pair_we, mark_we, mark_wdata, step_we;
    logic [PW-1:0]     pair_waddr, pair_raddr, mark_waddr;
    logic [PWW-1:0]    pair_wdata, pair_rdata;
    logic              mark_rdata;
    logic [SW-1:0]     step_waddr;
    logic [STW-1:0]    step_wdata, step_rdata;

    mcvl_pkg::pair_word_t pair_rd;
    mcvl_pkg::step_rec_t  step_rd, step_new;

    mcvl_pkg::div_req_t div_req;
    mcvl_pkg::div_rsp_t div_rsp;

    // Item decode.
    logic               accept;
    logic               st_in_range, act_in_range, explore, buf_full;
    logic [AW-1:0]      rand_act;
    logic               out_free;
    logic               clr_last, walk_last;

    // Arithmetic.
    logic [PW-1:0]          k_now;
    logic [ACW-1:0]         sel_off;
    logic                   sel_better;
    logic [ACW-1:0]         sel_final_act;
    logic signed [VW+16:0]  prod_rnd;
    logic signed [VW+1:0]   g_acc;
    logic signed [VW-1:0]   g_new;
    logic signed [SUMW:0]   sum_acc;
    logic signed [SUMW-1:0] sum_sat;
    logic [CW-1:0]          cnt_inc;
    logic [2*RW-1:0]        dec_prod;
    logic [RW-1:0]          rate_dec;

    assign pair_rd = mcvl_pkg::pair_word_t'(pair_rdata);
    assign step_rd = mcvl_pkg::step_rec_t'(step_rdata);

    assign accept       = s_valid && s_ready;
    assign st_in_range  = 32'(s_item.state_index) < 32'(STATE_COUNT);
    assign act_in_range = 32'(s_item.action_index) < 32'(ACTION_COUNT);
    assign explore      = s_item.random_fraction < rate_reg;
    assign buf_full     = step_cnt_reg == SCW'(STEP_DEPTH);
    assign rand_act     = (32'(s_item.random_action) < 32'(ACTION_COUNT)) ?
                          s_item.random_action : AW'(ACTION_COUNT - 1);
    assign out_free     = !m_valid_reg || m_ready;
    assign clr_last     = clr_cnt_reg == PW'(PAIRS - 1);
    assign walk_last    = t_reg == '0;

    // Pair index of the buffered step: state times the row length plus the action.
    assign k_now = PW'(step_rd.st) * PW'(ACTION_COUNT) + PW'(step_rd.act);

    // Select scan: the entry read last cycle is compared, the first maximum wins.
    assign sel_off       = (32'(sel_cnt_reg) < 32'(ACTION_COUNT)) ? sel_cnt_reg : '0;
    assign sel_better    = (sel_cnt_reg == ACW'(1)) || (pair_rd.value > best_val_reg);
    assign sel_final_act = sel_better ? (sel_cnt_reg - 1'b1) : best_act_reg;

    // Discounted return: gamma * G rounded to nearest, ties up, plus the step reward.
    assign prod_rnd = (prod_reg + (VW+17)'(32768)) >>> 16;
    assign g_acc    = (VW+2)'(prod_rnd) + (VW+2)'(rew_reg);

    always_comb begin
        if (g_acc > (VW+2)'(2147483647)) begin
            g_new = {1'b0, {(VW-1){1'b1}}};
        end else if (g_acc < (VW+2)'(-64'sd2147483648)) begin
            g_new = {1'b1, {(VW-1){1'b0}}};
        end else begin
            g_new = VW'(g_acc);
        end
    end

    // Return sum saturates to 48 bits and the visit count sticks at its maximum.
    assign sum_acc = (SUMW+1)'(pword_reg.sum) + (SUMW+1)'(g_reg);

    always_comb begin
        if (sum_acc[SUMW] != sum_acc[SUMW-1]) begin
            sum_sat = sum_acc[SUMW] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
        end else begin
            sum_sat = SUMW'(sum_acc);
        end
    end

    assign cnt_inc = (&pword_reg.count) ? pword_reg.count : pword_reg.count + 1'b1;

    // Epsilon decay, truncated, then held at the floor.
    assign dec_prod = rate_reg * decay_reg;
    assign rate_dec = (dec_prod[2*RW-1:RW] < floor_reg) ? floor_reg : dec_prod[2*RW-1:RW];

    // Result fields that are already known when the item is taken.
    always_comb begin
        res_init = '0;
        if (s_item.operation == mcvl_pkg::OP_SELECT && explore) begin
            res_init.chosen_action = rand_act;
            res_init.explored      = 1'b1;
        end
        if (s_item.operation == mcvl_pkg::OP_RECORD) begin
            res_init.buffer_full = buf_full;
        end
        if (s_item.operation == mcvl_pkg::OP_END) begin
            res_init.episodes_done = episodes_reg;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcvl_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = mcvl_pkg::ST_IDLE;
                end
            end
            mcvl_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = mcvl_pkg::ST_RESP;
                    if (s_item.operation == mcvl_pkg::OP_SELECT && !explore && st_in_range) begin
                        state_next = mcvl_pkg::ST_SEL;
                    end else if (s_item.operation == mcvl_pkg::OP_END && step_cnt_reg != '0) begin
                        state_next = mcvl_pkg::ST_WALK_RD;
                    end
                end
            end
            mcvl_pkg::ST_SEL: begin
                if (32'(sel_cnt_reg) == 32'(ACTION_COUNT)) begin
                    state_next = mcvl_pkg::ST_RESP;
                end
            end
            mcvl_pkg::ST_WALK_RD:  state_next = mcvl_pkg::ST_WALK_MUL;
            mcvl_pkg::ST_WALK_MUL: state_next = mcvl_pkg::ST_WALK_G;
            mcvl_pkg::ST_WALK_G:   state_next = mcvl_pkg::ST_WALK_SUM;
            mcvl_pkg::ST_WALK_SUM: begin
                if (!mark_reg) begin
                    state_next = mcvl_pkg::ST_WALK_DIV;
                end else if (walk_last) begin
                    state_next = mcvl_pkg::ST_MARK_CLR;
                end else begin
                    state_next = mcvl_pkg::ST_WALK_RD;
                end
            end
            mcvl_pkg::ST_WALK_DIV: begin
                if (div_rsp.done) begin
                    state_next = walk_last ? mcvl_pkg::ST_MARK_CLR : mcvl_pkg::ST_WALK_RD;
                end
            end
            mcvl_pkg::ST_MARK_CLR: begin
                if (clr_last) begin
                    state_next = mcvl_pkg::ST_DECAY;
                end
            end
            mcvl_pkg::ST_DECAY: state_next = mcvl_pkg::ST_RESP;
            mcvl_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = mcvl_pkg::ST_IDLE;
                end
            end
            default: state_next = mcvl_pkg::ST_CLEAR;
        endcase
    end

    // Memory controls and handshake outputs.
    always_comb begin
        s_ready     = state_reg == mcvl_pkg::ST_IDLE;
        pair_we     = 1'b0;
        pair_waddr  = k_reg;
        pair_wdata  = PWW'(mcvl_pkg::pair_word_t'{value: div_rsp.quotient, sum: sum_reg,
                                                  count: cnt_reg});
        pair_raddr  = (state_reg == mcvl_pkg::ST_SEL) ? base_reg + PW'(sel_off) : k_now;
        mark_we     = 1'b0;
        mark_waddr  = k_reg;
        mark_wdata  = 1'b1;
        step_we     = 1'b0;
        step_waddr  = step_cnt_reg[SW-1:0];
        step_new    = '{st: s_item.state_index, act: s_item.action_index,
                        rew: s_item.reward_value};
        step_wdata  = STW'(step_new);
        div_req     = '{start: 1'b0, dividend: sum_sat, divisor: cnt_inc};
        case (state_reg)
            mcvl_pkg::ST_CLEAR: begin
                pair_we    = 1'b1;
                pair_waddr = clr_cnt_reg;
                pair_wdata = '0;
                mark_we    = 1'b1;
                mark_waddr = clr_cnt_reg;
                mark_wdata = 1'b0;
            end
            mcvl_pkg::ST_IDLE: begin
                step_we = accept && s_item.operation == mcvl_pkg::OP_RECORD && !buf_full &&
                          st_in_range && act_in_range;
            end
            mcvl_pkg::ST_WALK_SUM: begin
                mark_we       = !mark_reg;
                div_req.start = !mark_reg;
            end
            mcvl_pkg::ST_WALK_DIV: begin
                pair_we = div_rsp.done;
            end
            mcvl_pkg::ST_MARK_CLR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_cnt_reg;
                mark_wdata = 1'b0;
            end
            default: begin
                pair_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcvl_pkg::ST_CLEAR;
            gamma_reg    <= mcvl_pkg::DISCOUNT_RST;
            rate_reg     <= mcvl_pkg::START_RST;
            floor_reg    <= mcvl_pkg::FLOOR_RST;
            decay_reg    <= mcvl_pkg::DECAY_RST;
            bonus_reg    <= mcvl_pkg::BONUS_RST;
            episodes_reg <= '0;
            step_cnt_reg <= '0;
            clr_cnt_reg  <= '0;
            sel_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (mcvl_pkg::cfg_idx_t'(cfg_index))
                    mcvl_pkg::CFG_DISCOUNT:   gamma_reg <= cfg_wdata[RW-1:0];
                    mcvl_pkg::CFG_EXPL_START: rate_reg  <= cfg_wdata[RW-1:0];
                    mcvl_pkg::CFG_EXPL_FLOOR: floor_reg <= cfg_wdata[RW-1:0];
                    mcvl_pkg::CFG_EXPL_DECAY: decay_reg <= cfg_wdata[RW-1:0];
                    mcvl_pkg::CFG_WIN_BONUS:  bonus_reg <= cfg_wdata[VW-1:0];
                    default: begin
                        gamma_reg <= gamma_reg;
                    end
                endcase
            end

            if (state_reg == mcvl_pkg::ST_CLEAR || state_reg == mcvl_pkg::ST_MARK_CLR) begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            end

            if (state_reg == mcvl_pkg::ST_IDLE) begin
                sel_cnt_reg <= '0;
            end else if (state_reg == mcvl_pkg::ST_SEL) begin
                sel_cnt_reg <= sel_cnt_reg + 1'b1;
            end

            if (step_we) begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end else if (accept && s_item.operation == mcvl_pkg::OP_START) begin
                step_cnt_reg <= '0;
            end else if (state_reg == mcvl_pkg::ST_DECAY) begin
                step_cnt_reg <= '0;
            end

            if (state_reg == mcvl_pkg::ST_DECAY) begin
                episodes_reg <= episodes_reg + 1'b1;
                rate_reg     <= rate_dec;
            end

            if (state_reg == mcvl_pkg::ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            mcvl_pkg::ST_IDLE: begin
                base_reg <= PW'(s_item.state_index) * PW'(ACTION_COUNT);
                t_reg    <= SW'(step_cnt_reg - 1'b1);
                g_reg    <= s_item.episode_won ? bonus_reg : '0;
                res_reg  <= res_init;
            end
            mcvl_pkg::ST_SEL: begin
                if (sel_cnt_reg != '0 && sel_better) begin
                    best_val_reg <= pair_rd.value;
                    best_act_reg <= sel_cnt_reg - 1'b1;
                end
                res_reg.chosen_action <= AW'(sel_final_act);
            end
            mcvl_pkg::ST_WALK_MUL: begin
                prod_reg <= (VW+17)'(g_reg) * (VW+17)'($signed({1'b0, gamma_reg}));
                rew_reg  <= step_rd.rew;
                k_reg    <= k_now;
            end
            mcvl_pkg::ST_WALK_G: begin
                g_reg     <= g_new;
                pword_reg <= pair_rd;
                mark_reg  <= mark_rdata;
            end
            mcvl_pkg::ST_WALK_SUM: begin
                sum_reg <= sum_sat;
                cnt_reg <= cnt_inc;
                if (mark_reg) begin
                    t_reg <= t_reg - 1'b1;
                end
            end
            mcvl_pkg::ST_WALK_DIV: begin
                if (div_rsp.done) begin
                    t_reg <= t_reg - 1'b1;
                end
            end
            mcvl_pkg::ST_DECAY: begin
                res_reg <= '{chosen_action: '0, explored: 1'b0, episode_return: g_reg,
                             episodes_done: episodes_reg + 1'b1, buffer_full: 1'b0};
            end
            mcvl_pkg::ST_RESP: begin
                if (out_free) begin
                    m_item_reg <= res_reg;
                end
            end
            default: begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Value, return sum and visit count of every state-action pair share one word.
    mcvl_ram #(
        .WIDTH (PWW),
        .DEPTH (PAIRS)
    ) u_pair_mem (
        .aclk  (aclk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    // First-visit marks, swept clear at the end of every episode that has buffered steps.
    mcvl_ram #(
        .WIDTH (1),
        .DEPTH (PAIRS)
    ) u_mark_mem (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (k_now),
        .rdata (mark_rdata)
    );

    // Steps of the current episode; entries beyond the count are never used.
    mcvl_ram #(
        .WIDTH (STW),
        .DEPTH (STEP_DEPTH)
    ) u_step_mem (
        .aclk  (aclk),
        .we    (step_we),
        .waddr (step_waddr),
        .wdata (step_wdata),
        .raddr (t_reg),
        .rdata (step_rdata)
    );

    mcvl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // The step count never runs past the buffer depth.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_cnt_reg <= SCW'(STEP_DEPTH))
        else $error("step count beyond buffer depth");

    // A new division is only started once the previous one has finished.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // No item is taken while a division is still in flight.
    a_ready_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_rsp.busy)
        else $error("item accepted during division");

    // After an episode ends epsilon sits at or above its floor and the buffer is empty.
    a_decay: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mcvl_pkg::ST_DECAY |=> (rate_reg >= floor_reg) && (step_cnt_reg == '0))
        else $error("episode end left epsilon or step count wrong");

endmodule

// ===== tb/tb_first_visit_mc_value_learner_core.sv =====
// Self-checking testbench of the first-visit Monte Carlo value learner core.
module tb_first_visit_mc_value_learner_core;

    localparam int NSTATE  = mcvl_pkg::STATE_COUNT_DEF;
    localparam int NACTION = mcvl_pkg::ACTION_COUNT_DEF;
    localparam int NSTEP   = mcvl_pkg::STEP_DEPTH_DEF;
    localparam int NPAIR   = NSTATE * NACTION;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355327 - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [mcvl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mcvl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    mcvl_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    mcvl_pkg::out_item_t m_item;

    first_visit_mc_value_learner_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the learner's registers and tables.
    logic [15:0] gamma_q, eps_start_q, eps_floor_q, eps_decay_q, eps_now;
    longint bonus_q;
    longint q_value [NPAIR];
    longint ret_sum [NPAIR];
    int unsigned visits [NPAIR];
    bit seen [NPAIR];
    mcvl_pkg::step_rec_t episode_steps [NSTEP];
    int unsigned n_steps;
    int unsigned n_episodes;

    mcvl_pkg::out_item_t pending_results[$];
    int mismatches = 0;
    bit failed = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Floor shift by 16, arithmetic for negative products.
    function automatic longint floor_shift16(longint x);
        if (x >= 0) return x >>> 16;
        return -(((-x) - 1) >>> 16) - 1;
    endfunction

    // Appends one expected result to the scoreboard queue.
    function automatic void expect_result(mcvl_pkg::out_item_t r);
        pending_results = {pending_results, r};
    endfunction

    task automatic reset_learner();
        gamma_q = mcvl_pkg::DISCOUNT_RST; eps_start_q = mcvl_pkg::START_RST;
        eps_floor_q = mcvl_pkg::FLOOR_RST; eps_decay_q = mcvl_pkg::DECAY_RST;
        bonus_q = mcvl_pkg::BONUS_RST; eps_now = mcvl_pkg::START_RST;
        foreach (q_value[i]) begin
            q_value[i] = 0; ret_sum[i] = 0; visits[i] = 0; seen[i] = 0;
        end
        n_steps = 0; n_episodes = 0;
    endtask

    task automatic write_learner_reg(mcvl_pkg::cfg_idx_t idx, logic [31:0] data);
        case (idx)
            mcvl_pkg::CFG_DISCOUNT: gamma_q = data[15:0];
            mcvl_pkg::CFG_EXPL_START: begin
                eps_start_q = data[15:0]; eps_now = data[15:0];
            end
            mcvl_pkg::CFG_EXPL_FLOOR: eps_floor_q = data[15:0];
            mcvl_pkg::CFG_EXPL_DECAY: eps_decay_q = data[15:0];
            mcvl_pkg::CFG_WIN_BONUS: bonus_q = longint'($signed(data));
            default: ;
        endcase
    endtask

    // Works out the result of one item and advances the shadow state.
    function automatic mcvl_pkg::out_item_t learn_step(mcvl_pkg::in_item_t it);
        mcvl_pkg::out_item_t r;
        longint g, best_v, total;
        int unsigned k, best;
        longint unsigned dec;
        r = '0;
        case (it.operation)
            mcvl_pkg::OP_SELECT: begin
                if (it.random_fraction < eps_now) begin
                    r.chosen_action = (it.random_action < NACTION) ? it.random_action
                                                                   : 3'(NACTION - 1);
                    r.explored = 1'b1;
                end else if (it.state_index < NSTATE) begin
                    k = it.state_index * NACTION;
                    best = 0;
                    best_v = q_value[k];
                    for (int a = 1; a < NACTION; a++) begin
                        if (q_value[k + a] > best_v) begin
                            best_v = q_value[k + a]; best = a;
                        end
                    end
                    r.chosen_action = 3'(best);
                end
            end
            mcvl_pkg::OP_RECORD: begin
                if (n_steps >= NSTEP) r.buffer_full = 1'b1;
                else if (it.state_index < NSTATE && it.action_index < NACTION) begin
                    episode_steps[n_steps] = '{it.state_index, it.action_index, it.reward_value};
                    n_steps++;
                end
            end
            mcvl_pkg::OP_END: begin
                if (n_steps > 0) begin
                    g = it.episode_won ? bonus_q : 0;
                    for (int t = int'(n_steps) - 1; t >= 0; t--) begin
                        g = clamp32(floor_shift16(g * longint'(gamma_q) + 32768)
                                    + longint'(episode_steps[t].rew));
                        k = episode_steps[t].st * NACTION + episode_steps[t].act;
                        if (!seen[k]) begin
                            seen[k] = 1;
                            total = ret_sum[k] + g;
                            if (total > SUM_HI) total = SUM_HI;
                            if (total < SUM_LO) total = SUM_LO;
                            ret_sum[k] = total;
                            if (visits[k] != 32'hFFFF_FFFF) visits[k]++;
                            q_value[k] = clamp32(total / longint'(visits[k]));
                        end
                    end
                    foreach (seen[i]) seen[i] = 0;
                    n_steps = 0;
                    n_episodes++;
                    dec = (longint'(eps_now) * longint'(eps_decay_q)) >> 16;
                    eps_now = (dec < eps_floor_q) ? eps_floor_q : 16'(dec);
                    r.episode_return = 32'(g);
                end
                r.episodes_done = n_episodes;
            end
            default: n_steps = 0;
        endcase
        return r;
    endfunction

    // Receiver: stalls in a pattern of its own and checks every accepted result.
    int unsigned stall_mode = 0;
    always @(posedge aclk) begin
        mcvl_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                failed = 1;
                if (mismatches < 10) $display("unexpected result %p", m_item);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_item !== want) begin
                    failed = 1;
                    if (mismatches < 10) $display("mismatch: expected %p, got %p", want, m_item);
                    mismatches++;
                end
            end
        end
    end

    // The stall pattern changes every so often; mode 0 is a stretch of no stalls.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ($urandom_range(0, 20) == 0);
        endcase
    end

    // Sender: bursts of random length separated by random gaps. Valid stays high across
    // items of a burst and drops only for a gap.
    int unsigned burst_left = 0;
    task automatic send_item(mcvl_pkg::in_item_t it, bit has_fixed, mcvl_pkg::out_item_t fixed);
        mcvl_pkg::out_item_t r;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_item <= it;
        s_valid <= 1'b1;
        r = learn_step(it);
        // A typed-in expectation stands in for the predictor on a few rows.
        if (has_fixed) begin
            if (fixed !== r) begin
                failed = 1;
                $display("directed row disagrees with prediction: %p vs %p", fixed, r);
            end
            expect_result(fixed);
        end else expect_result(r);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic cfg_write(mcvl_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= data;
        write_learner_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic mcvl_pkg::in_item_t make_item(mcvl_pkg::op_t op, int st, int act,
                                                     logic [31:0] rew, bit won, int frac,
                                                     int ract);
        mcvl_pkg::in_item_t it;
        it.operation = op; it.state_index = 10'(st); it.action_index = 3'(act);
        it.reward_value = rew; it.episode_won = won;
        it.random_fraction = 16'(frac); it.random_action = 3'(ract);
        return it;
    endfunction

    function automatic mcvl_pkg::out_item_t make_result(int act, bit expl, logic [31:0] ret,
                                                        int unsigned done, bit full);
        mcvl_pkg::out_item_t r;
        r.chosen_action = 3'(act); r.explored = expl; r.episode_return = ret;
        r.episodes_done = done; r.buffer_full = full;
        return r;
    endfunction

    // Directed rows: item, whether an expectation is typed in, and that expectation.
    typedef struct {
        mcvl_pkg::in_item_t   it;
        bit                   fixed;
        mcvl_pkg::out_item_t  res;
    } directed_row_t;

    // Random state/action within a small neighborhood so pairs repeat within episodes.
    function automatic mcvl_pkg::in_item_t rand_item(mcvl_pkg::op_t op, int hot_states);
        mcvl_pkg::in_item_t it;
        it.operation = op;
        it.state_index = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, hot_states));
        it.action_index = ($urandom_range(0, 15) == 0) ? 3'($urandom)
                                                       : 3'($urandom_range(0, NACTION - 1));
        case ($urandom_range(0, 5))
            0: it.reward_value = $urandom;
            1: it.reward_value = 32'sh7FFF_FFFF;
            2: it.reward_value = 32'sh8000_0000;
            default: it.reward_value = 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
        it.episode_won = 1'($urandom);
        it.random_fraction = 16'($urandom);
        it.random_action = 3'($urandom);
        return it;
    endfunction

    // Noise items and random episodes: a start, a few records mixed with selects, then an end.
    task automatic run_episodes(int n_items);
        int sent;
        int len;
        mcvl_pkg::in_item_t it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // Noise: any operation with any fields.
                it = mcvl_pkg::in_item_t'({$urandom, $urandom, 3'($urandom)});
                send_item(it, 0, '0);
                sent++;
            end else begin
                send_item(rand_item(mcvl_pkg::OP_START, 15), 0, '0);
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_item(rand_item(($urandom_range(0, 3) == 0) ? mcvl_pkg::OP_SELECT
                                                                    : mcvl_pkg::OP_RECORD, 15),
                              0, '0);
                end
                send_item(rand_item(mcvl_pkg::OP_END, 15), 0, '0);
                sent += len + 2;
            end
        end
    endtask

    directed_row_t directed[$];

    function automatic void add_row(directed_row_t row);
        directed = {directed, row};
    endfunction

    initial begin
        reset_learner();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // After reset: exploit picks action 0, end with no steps gives zeros.
        add_row('{make_item(mcvl_pkg::OP_SELECT, 0, 0, 0, 0, 65535, 0), 1,
                  make_result(0, 0, 0, 0, 0)});
        add_row('{make_item(mcvl_pkg::OP_END, 0, 0, 0, 1, 0, 0), 1,
                  make_result(0, 0, 0, 0, 0)});
        // Random fraction below epsilon explores; an out-of-range random action saturates.
        add_row('{make_item(mcvl_pkg::OP_SELECT, 5, 0, 0, 0, 0, 7), 1,
                  make_result(6, 1, 0, 0, 0)});
        add_row('{make_item(mcvl_pkg::OP_SELECT, 5, 0, 0, 0, 0, 3), 1,
                  make_result(3, 1, 0, 0, 0)});
        // Out-of-range record fields are dropped quietly.
        add_row('{make_item(mcvl_pkg::OP_RECORD, 1023, 7, 32'h1234, 0, 0, 0), 1,
                  make_result(0, 0, 0, 0, 0)});
        add_row('{make_item(mcvl_pkg::OP_START, 0, 0, 0, 0, 0, 0), 1,
                  make_result(0, 0, 0, 0, 0)});
        // Extreme rewards, a repeated pair and the top state.
        add_row('{make_item(mcvl_pkg::OP_RECORD, 1023, 6, 32'h7FFF_FFFF, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_RECORD, 0, 0, 32'h8000_0000, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_RECORD, 1023, 6, 32'h0001_0000, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_END, 0, 0, 0, 1, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_SELECT, 1023, 0, 0, 0, 65535, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_RECORD, 3, 2, 32'h0005_0000, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_START, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_END, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_RECORD, 3, 2, 32'hFFFB_0000, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_END, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{make_item(mcvl_pkg::OP_SELECT, 3, 0, 0, 0, 65535, 0), 0, '0});
        foreach (directed[i]) send_item(directed[i].it, directed[i].fixed, directed[i].res);
        wait_drained();

        // Default settings, then extremes, then random settings, then a new epsilon and bonus.
        run_episodes(350);
        wait_drained();
        cfg_write(mcvl_pkg::CFG_DISCOUNT, 32'd0);
        cfg_write(mcvl_pkg::CFG_EXPL_START, 32'd65535);
        cfg_write(mcvl_pkg::CFG_EXPL_FLOOR, 32'd65535);
        cfg_write(mcvl_pkg::CFG_EXPL_DECAY, 32'd0);
        cfg_write(mcvl_pkg::CFG_WIN_BONUS, 32'h7FFF_FFFF);
        run_episodes(250);
        wait_drained();
        cfg_write(mcvl_pkg::CFG_DISCOUNT, 32'd65535);
        cfg_write(mcvl_pkg::CFG_EXPL_START, 32'd0);
        cfg_write(mcvl_pkg::CFG_EXPL_FLOOR, 32'd0);
        cfg_write(mcvl_pkg::CFG_EXPL_DECAY, 32'd65535);
        cfg_write(mcvl_pkg::CFG_WIN_BONUS, 32'h8000_0000);
        run_episodes(250);
        wait_drained();
        cfg_write(mcvl_pkg::CFG_DISCOUNT, $urandom_range(30000, 65535));
        cfg_write(mcvl_pkg::CFG_EXPL_START, $urandom);
        cfg_write(mcvl_pkg::CFG_EXPL_FLOOR, $urandom_range(0, 3000));
        cfg_write(mcvl_pkg::CFG_EXPL_DECAY, $urandom);
        cfg_write(mcvl_pkg::CFG_WIN_BONUS, $urandom);
        run_episodes(300);
        wait_drained();
        cfg_write(mcvl_pkg::CFG_EXPL_START, 32'd20000);
        cfg_write(mcvl_pkg::CFG_WIN_BONUS, mcvl_pkg::BONUS_RST);
        run_episodes(300);

        wait_drained();
        if (!failed) begin
            $display("tb_first_visit_mc_value_learner_core passed");
        end else begin
            $display("tb_first_visit_mc_value_learner_core failed");
        end
        $finish;
    end

    // Hard limit: every end of an episode with buffered steps sweeps all marks, and even with slow
    // stalls the whole run fits well inside.
    initial begin
        #(64'd500_000_000);
        $display("tb_first_visit_mc_value_learner_core failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/mcvl_pkg.sv
rtl/mcvl_ram.sv
rtl/mcvl_div.sv
rtl/first_visit_mc_value_learner_core.sv
tb/tb_first_visit_mc_value_learner_core.sv
